// ----- src/gti_pkg.sv -----
// Types and codes shared by the grid trilinear interpolator.
package gti_pkg;

  // Item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;
  localparam logic [1:0] KIND_INTERP = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_PTS   = 3'd6;

  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [4:0]         index_x;
    logic [4:0]         index_y;
    logic [4:0]         index_z;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               out_of_range;
  } out_item_t;

endpackage

// ----- src/grid_trilinear_interpolator.sv -----
// Grid trilinear interpolator: grid store, sequencer and shared multiplier.
//
// Holds a grid of up to POINTS_X_MAX x POINTS_Y_MAX x POINTS_Z_MAX Q16.16
// values in one single-port memory (registered read) and serves one item at
// a time: in_stall is high from acceptance until the result has been moved
// into the output register, which then waits for the sink independently.
// After reset the memory is cleared one word a cycle, with in_stall held high
// through the whole sweep of all POINTS_X_MAX*POINTS_Y_MAX*POINTS_Z_MAX words
// (configuration writes are taken throughout; cfg_ready is always high).
// Interpolation uses the shared 33x33 multiplier and the one memory port:
// three position multiplies (multiply, then clamp and split), eight corner
// reads through the registered read, then seven rounded lerps (multiply,
// then add and round). Axes with a single point collapse to index 0 and
// fraction 0, giving bilinear, linear or point results. Positions are
// clamped to the grid edge; read or write indexes outside the active grid
// raise out_of_range and leave the store untouched.
module grid_trilinear_interpolator #(
  parameter int POINTS_X_MAX = 16,
  parameter int POINTS_Y_MAX = 16,
  parameter int POINTS_Z_MAX = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gti_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gti_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int DEPTH = POINTS_X_MAX * POINTS_Y_MAX * POINTS_Z_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Axis counts come from 4-bit fields, so never exceed 16
  localparam int NXC = (POINTS_X_MAX < 16) ? POINTS_X_MAX : 16;
  localparam int NYC = (POINTS_Y_MAX < 16) ? POINTS_Y_MAX : 16;
  localparam int NZC = (POINTS_Z_MAX < 16) ? POINTS_Z_MAX : 16;

  // State codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_LMUL  = 4'd4;
  localparam logic [3:0] S_LFIN  = 4'd5;
  localparam logic [3:0] S_CORN  = 4'd6;
  localparam logic [3:0] S_BMUL  = 4'd7;
  localparam logic [3:0] S_BFIN  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Configuration
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        scale_x, scale_y, scale_z;
  logic [11:0]        grid_points;

  // Sequencer
  logic [3:0]         state;
  logic [1:0]         ax;
  logic [3:0]         cnt;
  logic [2:0]         step;
  logic [AW-1:0]      clr;
  logic [3:0]         fill_x, fill_y, fill_z;

  // Datapath
  gti_pkg::in_item_t  item;
  logic               outside;
  logic signed [31:0] res_val;
  logic               res_flag;
  logic signed [65:0] prod;
  logic               diff_pos;
  logic [3:0]         lo [3];
  logic [3:0]         hi [3];
  logic [16:0]        fr [3];
  logic signed [31:0] v [8];
  logic signed [31:0] w [6];

  // Memory
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic signed [31:0] mem_wd;

  logic [4:0]         nx, ny, nz, cur_n;
  logic               accept, in_inside;
  logic signed [31:0] cur_coord, cur_org;
  logic [31:0]        cur_scale;
  logic signed [32:0] diff;
  logic signed [32:0] mul_a, mul_b;
  logic [47:0]        pos_raw;
  logic [19:0]        limit, pos;
  logic [3:0]         idx_raw, idx, nm1, nm2;
  logic [16:0]        frac;
  logic signed [31:0] ba, bb;
  logic [16:0]        bf;
  logic signed [65:0] bsum;
  logic signed [31:0] bres;
  logic               fill_last;
  logic               out_free;

  function automatic logic [AW-1:0] addr_of(input logic [3:0] x, input logic [3:0] y,
                                            input logic [3:0] z);
    addr_of = AW'((32'(x) * 32'(POINTS_Y_MAX) + 32'(y)) * 32'(POINTS_Z_MAX) + 32'(z));
  endfunction

  function automatic logic [4:0] axis_n(input logic [3:0] f, input int lim);
    logic [4:0] n;
    n = 5'(f) + 5'd1;
    axis_n = (n > 5'(lim)) ? 5'(lim) : n;
  endfunction

  assign nx = axis_n(grid_points[3:0], NXC);
  assign ny = axis_n(grid_points[7:4], NYC);
  assign nz = axis_n(grid_points[11:8], NZC);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_inside = (in_data.index_x < nx) && (in_data.index_y < ny) &&
                     (in_data.index_z < nz);
  assign out_free  = !out_valid || !out_stall;
  assign fill_last = ({1'b0, fill_x} == nx - 5'd1) && ({1'b0, fill_y} == ny - 5'd1) &&
                     ({1'b0, fill_z} == nz - 5'd1);

  // Per-axis selection for the position step
  always_comb begin
    case (ax)
      2'd0: begin
        cur_coord = item.coord_x; cur_org = origin_x; cur_scale = scale_x; cur_n = nx;
      end
      2'd1: begin
        cur_coord = item.coord_y; cur_org = origin_y; cur_scale = scale_y; cur_n = ny;
      end
      default: begin
        cur_coord = item.coord_z; cur_org = origin_z; cur_scale = scale_z; cur_n = nz;
      end
    endcase
  end

  assign diff = 33'(cur_coord) - 33'(cur_org);

  // Lerp operands by step: four along x, two along y, one along z
  always_comb begin
    case (step)
      3'd0: begin ba = v[0]; bb = v[1]; bf = fr[0]; end
      3'd1: begin ba = v[2]; bb = v[3]; bf = fr[0]; end
      3'd2: begin ba = v[4]; bb = v[5]; bf = fr[0]; end
      3'd3: begin ba = v[6]; bb = v[7]; bf = fr[0]; end
      3'd4: begin ba = w[0]; bb = w[1]; bf = fr[1]; end
      3'd5: begin ba = w[2]; bb = w[3]; bf = fr[1]; end
      default: begin ba = w[4]; bb = w[5]; bf = fr[2]; end
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    if (state == S_LMUL) begin
      mul_a = $signed({1'b0, diff[31:0]});
      mul_b = $signed({1'b0, cur_scale});
    end else begin
      mul_a = 33'(bb) - 33'(ba);
      mul_b = $signed({16'b0, bf});
    end
  end

  // Position: clamp to last point, split into cell index and fraction
  always_comb begin
    pos_raw = diff_pos ? 48'(prod[63:16]) : 48'd0;
    nm1     = 4'(cur_n - 5'd1);
    nm2     = 4'(cur_n - 5'd2);
    limit   = {nm1, 16'b0};
    pos     = (pos_raw > 48'(limit)) ? limit : pos_raw[19:0];
    idx_raw = pos[19:16];
    idx     = (idx_raw > nm2) ? nm2 : idx_raw;
    frac    = (idx_raw != idx) ? 17'h1_0000 : {1'b0, pos[15:0]};
  end

  // a*(1-f) + b*f = a<<16 + (b-a)*f, rounded half up
  assign bsum = $signed({{18{ba[31]}}, ba, 16'b0}) + prod + 66'sd32768;
  assign bres = bsum[47:16];

  // Memory port
  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = item.write_value;
    mem_addr = addr_of(in_data.index_x[3:0], in_data.index_y[3:0], in_data.index_z[3:0]);
    case (state)
      S_IDLE: begin
        mem_we = accept && (in_data.kind == gti_pkg::KIND_WRITE) && in_inside;
        mem_wd = in_data.write_value;
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wd   = '0;
        mem_addr = clr;
      end
      S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = addr_of(fill_x, fill_y, fill_z);
      end
      S_CORN: begin
        mem_addr = addr_of(cnt[0] ? hi[0] : lo[0], cnt[1] ? hi[1] : lo[1],
                           cnt[2] ? hi[2] : lo[2]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_data <= mem[mem_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      scale_x     <= gti_pkg::SCALE_ONE;
      scale_y     <= gti_pkg::SCALE_ONE;
      scale_z     <= gti_pkg::SCALE_ONE;
      grid_points <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gti_pkg::CFG_ORIGIN_X: origin_x    <= cfg_data;
        gti_pkg::CFG_ORIGIN_Y: origin_y    <= cfg_data;
        gti_pkg::CFG_ORIGIN_Z: origin_z    <= cfg_data;
        gti_pkg::CFG_SCALE_X:  scale_x     <= cfg_data;
        gti_pkg::CFG_SCALE_Y:  scale_y     <= cfg_data;
        gti_pkg::CFG_SCALE_Z:  scale_z     <= cfg_data;
        gti_pkg::CFG_GRID_PTS: grid_points <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      ax        <= '0;
      cnt       <= '0;
      step      <= '0;
      fill_x    <= '0;
      fill_y    <= '0;
      fill_z    <= '0;
    end else begin
      // the hand-over state reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item     <= in_data;
            outside  <= !in_inside;
            res_val  <= '0;
            res_flag <= 1'b0;
            ax       <= '0;
            cnt      <= '0;
            step     <= '0;
            fill_x   <= '0;
            fill_y   <= '0;
            fill_z   <= '0;
            case (in_data.kind)
              gti_pkg::KIND_WRITE: begin
                res_flag <= !in_inside;
                state    <= S_DONE;
              end
              gti_pkg::KIND_READ:  state <= S_RDW;
              gti_pkg::KIND_FILL:  state <= S_FILL;
              default:             state <= S_LMUL;
            endcase
          end
        end
        S_FILL: begin
          // z fastest, then y, then x
          if (fill_last) begin
            state <= S_DONE;
          end else if ({1'b0, fill_z} != nz - 5'd1) begin
            fill_z <= fill_z + 4'd1;
          end else begin
            fill_z <= '0;
            if ({1'b0, fill_y} != ny - 5'd1) begin
              fill_y <= fill_y + 4'd1;
            end else begin
              fill_y <= '0;
              fill_x <= fill_x + 4'd1;
            end
          end
        end
        S_RDW: begin
          res_val  <= outside ? 32'sd0 : rd_data;
          res_flag <= outside;
          state    <= S_DONE;
        end
        S_LMUL: begin
          prod     <= mul_a * mul_b;
          diff_pos <= (diff > 33'sd0);
          state    <= S_LFIN;
        end
        S_LFIN: begin
          if (cur_n <= 5'd1) begin
            lo[ax] <= '0;
            hi[ax] <= '0;
            fr[ax] <= '0;
          end else begin
            lo[ax] <= idx;
            hi[ax] <= idx + 4'd1;
            fr[ax] <= frac;
          end
          if (ax == 2'd2) begin
            state <= S_CORN;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_LMUL;
          end
        end
        S_CORN: begin
          // read data arrives in the cycle after its address
          if (cnt != 4'd0) begin
            v[3'(cnt - 4'd1)] <= rd_data;
          end
          if (cnt == 4'd8) begin
            state <= S_BMUL;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_BMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_BFIN;
        end
        S_BFIN: begin
          if (step == 3'd6) begin
            res_val <= bres;
            state   <= S_DONE;
          end else begin
            w[step] <= bres;
            step    <= step + 3'd1;
            state   <= S_BMUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.result_value <= res_val;
            out_data.out_of_range <= res_flag;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The store is not written while corners are fetched
  a_no_write_in_corners: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORN) |-> !mem_we)
    else $error("grid store written during corner fetch");

  // A result only appears from the hand-over state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("output valid raised outside hand-over");

  // Reset starts the clearing sweep, so no item is taken straight after it
  a_reset_stalls: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing sweep");

endmodule
